// File: design/vffm_pkg.sv
// vffm_pkg: shared widths, field offsets and codes for the fault-flag monitor
`timescale 1ns / 1ps

package vffm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HIGH_SEVERE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HIGH_MILD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW_SEVERE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW_MILD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SEVERE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MILD        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MAX         = 3'd6;

    localparam logic [15:0] RST_VOLT_HIGH_SEVERE = 16'd0;
    localparam logic [15:0] RST_VOLT_HIGH_MILD   = 16'd0;
    localparam logic [15:0] RST_VOLT_LOW_SEVERE  = 16'd0;
    localparam logic [15:0] RST_VOLT_LOW_MILD    = 16'd0;
    localparam logic [7:0]  RST_TEMP_SEVERE      = 8'd255;
    localparam logic [7:0]  RST_TEMP_MILD        = 8'd255;
    localparam logic [15:0] RST_DIFF_MAX         = 16'd65535;

    // aux rail window, 10 mV units
    localparam logic [15:0] AUX_HIGH = 16'd550;
    localparam logic [15:0] AUX_LOW  = 16'd450;

    // stream widths
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;

    localparam int NUM_MOTORS = 4;
    localparam int MILD_W     = 23;
    localparam int SEVERE_W   = 16;
    localparam int CRIT_W     = 5;

    // action kinds
    localparam logic ACT_MOTOR   = 1'b0;
    localparam logic ACT_BATTERY = 1'b1;

    // alarm levels
    localparam logic [2:0] LVL_NONE     = 3'd0;
    localparam logic [2:0] LVL_WARNING  = 3'd1;
    localparam logic [2:0] LVL_ALARM    = 3'd2;
    localparam logic [2:0] LVL_CRITICAL = 3'd3;

    // alarm codes
    localparam logic [2:0] CODE_PACK_V_HIGH = 3'd0;
    localparam logic [2:0] CODE_PACK_V_LOW  = 3'd1;
    localparam logic [2:0] CODE_PACK_I_HIGH = 3'd2;
    localparam logic [2:0] CODE_CELL_TEMP   = 3'd3;
    localparam logic [2:0] CODE_CHASSIS     = 3'd4;
    localparam logic [2:0] CODE_CELL_COMM   = 3'd5;
    localparam logic [2:0] CODE_SYSTEM      = 3'd6;

    // critical bit positions
    localparam int CRIT_CAN_LINK  = 0;
    localparam int CRIT_BMS_LINK  = 1;
    localparam int CRIT_CHASSIS   = 2;
    localparam int CRIT_CELL_COMM = 3;
    localparam int CRIT_SYSTEM    = 4;

endpackage

// File: design/vehicle_fault_flag_monitor.sv
// vehicle_fault_flag_monitor: fault-flag monitor for four motor controllers and a battery manager
//
// channels: s_axis takes one beat per motor sample or battery report, tuser marks which
// (0 motor sample, 1 battery report). m_axis returns one beat per input beat carrying the
// full mild, severe and critical flag vectors and the three any-flags after that update.
// a separate write channel (i_cfg_*) loads the seven threshold registers; index 7 is ignored.
// config writes are always taken and should only be issued while no beat is in flight.
// the result beat is registered and shows on m_axis in the cycle after the beat is accepted.
// throughput: one beat per cycle unless the receiver stalls; the flag update is a
// single pass of compares and bit logic on the stored flag registers, and the result
// is held in the output stage. when the receiver stalls, the result beat holds and
// s_axis_tready drops only if the pending result is not being taken in that cycle.
// reset (i_rst_n low, synchronous) clears all flags, drops m_axis_tvalid and loads the
// threshold registers with their defaults (0,0,0,0,255,255,65535).
`timescale 1ns / 1ps

module vehicle_fault_flag_monitor
    import vffm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // from bit 0: motor_index[2], pack_voltage[16], aux_voltage[16], battery_voltage[16],
    // temp_internal[8], temp_upper[8], temp_lower[8], can_link_error, bms_link_error,
    // alarm_level[3], alarm_code[3], zero pad[6]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // from bit 0: action
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // from bit 0: mild_flags[23], severe_flags[16], critical_flags[5], any_mild,
    // any_severe, any_critical, zero pad[1]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // threshold registers
    logic [15:0] r_volt_high_severe;
    logic [15:0] r_volt_high_mild;
    logic [15:0] r_volt_low_severe;
    logic [15:0] r_volt_low_mild;
    logic [7:0]  r_temp_severe;
    logic [7:0]  r_temp_mild;
    logic [15:0] r_diff_max;

    // flag state
    logic [7:0]  r_motor_flags [NUM_MOTORS];
    logic [2:0]  r_bat_mild;
    logic [3:0]  r_bat_severe;
    logic [4:0]  r_crit;
    logic        r_out_valid;

    logic [7:0]  n_motor_byte;
    logic [2:0]  n_bat_mild;
    logic [3:0]  n_bat_severe;
    logic [4:0]  n_crit;

    logic        w_in_accept;

    // unpacked input fields
    logic        w_action;
    logic [1:0]  w_motor_index;
    logic [15:0] w_pack;
    logic [15:0] w_aux;
    logic [15:0] w_bat;
    logic [7:0]  w_t_int;
    logic [7:0]  w_t_up;
    logic [7:0]  w_t_low;
    logic        w_can_err;
    logic        w_bms_err;
    logic [2:0]  w_level;
    logic [2:0]  w_code;

    logic [7:0]  w_t_max01;
    logic [7:0]  w_t_max;
    logic [15:0] w_diff;
    logic        w_code_low;
    logic [2:0]  w_code_oh;

    logic [MILD_W-1:0]   w_mild;
    logic [SEVERE_W-1:0] w_severe;

    assign w_action      = s_axis_tuser[0];
    assign w_motor_index = s_axis_tdata[1:0];
    assign w_pack        = s_axis_tdata[17:2];
    assign w_aux         = s_axis_tdata[33:18];
    assign w_bat         = s_axis_tdata[49:34];
    assign w_t_int       = s_axis_tdata[57:50];
    assign w_t_up        = s_axis_tdata[65:58];
    assign w_t_low       = s_axis_tdata[73:66];
    assign w_can_err     = s_axis_tdata[74];
    assign w_bms_err     = s_axis_tdata[75];
    assign w_level       = s_axis_tdata[78:76];
    assign w_code        = s_axis_tdata[81:79];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    // motor sample: every bit of the controller's flag byte is rewritten
    always_comb begin
        w_t_max01 = (w_t_up > w_t_int) ? w_t_up : w_t_int;
        w_t_max   = (w_t_low > w_t_max01) ? w_t_low : w_t_max01;
        w_diff    = (w_aux >= w_bat) ? (w_aux - w_bat) : (w_bat - w_aux);

        n_motor_byte[5] = w_pack > r_volt_high_severe;
        n_motor_byte[0] = !n_motor_byte[5] && (w_pack > r_volt_high_mild);
        n_motor_byte[6] = w_pack < r_volt_low_severe;
        n_motor_byte[1] = !n_motor_byte[6] && (w_pack < r_volt_low_mild);
        n_motor_byte[7] = w_t_max > r_temp_severe;
        n_motor_byte[2] = !n_motor_byte[7] && (w_t_max > r_temp_mild);
        n_motor_byte[3] = w_diff > r_diff_max;
        n_motor_byte[4] = (w_aux > AUX_HIGH) || (w_aux < AUX_LOW);
    end

    // battery report
    always_comb begin
        w_code_low = (w_code == CODE_PACK_V_HIGH) || (w_code == CODE_PACK_V_LOW)
                  || (w_code == CODE_PACK_I_HIGH);
        w_code_oh  = 3'b001 << w_code[1:0];

        n_bat_mild   = r_bat_mild;
        n_bat_severe = r_bat_severe;
        n_crit       = r_crit;
        if (w_can_err) begin
            n_crit[CRIT_CAN_LINK] = 1'b1;
        end
        if (w_bms_err) begin
            n_crit[CRIT_BMS_LINK] = 1'b1;
        end

        unique case (w_level)
            LVL_NONE: begin
                n_bat_mild   = 3'd0;
                n_bat_severe = 4'd0;
                n_crit[CRIT_SYSTEM:CRIT_CHASSIS] = 3'd0;
            end
            LVL_WARNING: begin
                if (w_code_low) begin
                    n_bat_mild   = r_bat_mild | w_code_oh;
                    n_bat_severe = r_bat_severe & ~{w_code_oh, 1'b0};
                end
            end
            LVL_ALARM: begin
                if (w_code_low) begin
                    n_bat_severe = r_bat_severe | {w_code_oh, 1'b0};
                    n_bat_mild   = r_bat_mild & ~w_code_oh;
                end else if (w_code == CODE_CELL_TEMP) begin
                    n_bat_severe[0] = 1'b1;
                end
            end
            LVL_CRITICAL: begin
                if (w_code == CODE_CHASSIS) begin
                    n_crit[CRIT_CHASSIS] = 1'b1;
                end else if (w_code == CODE_CELL_COMM) begin
                    n_crit[CRIT_CELL_COMM] = 1'b1;
                end else if (w_code == CODE_SYSTEM) begin
                    n_crit[CRIT_SYSTEM] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_high_severe <= RST_VOLT_HIGH_SEVERE;
            r_volt_high_mild   <= RST_VOLT_HIGH_MILD;
            r_volt_low_severe  <= RST_VOLT_LOW_SEVERE;
            r_volt_low_mild    <= RST_VOLT_LOW_MILD;
            r_temp_severe      <= RST_TEMP_SEVERE;
            r_temp_mild        <= RST_TEMP_MILD;
            r_diff_max         <= RST_DIFF_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_VOLT_HIGH_SEVERE: r_volt_high_severe <= i_cfg_data;
                CFG_VOLT_HIGH_MILD:   r_volt_high_mild   <= i_cfg_data;
                CFG_VOLT_LOW_SEVERE:  r_volt_low_severe  <= i_cfg_data;
                CFG_VOLT_LOW_MILD:    r_volt_low_mild    <= i_cfg_data;
                CFG_TEMP_SEVERE:      r_temp_severe      <= i_cfg_data[7:0];
                CFG_TEMP_MILD:        r_temp_mild        <= i_cfg_data[7:0];
                CFG_DIFF_MAX:         r_diff_max         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r_motor_flags[m] <= 8'd0;
            end
            r_bat_mild   <= 3'd0;
            r_bat_severe <= 4'd0;
            r_crit       <= 5'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_out_valid <= 1'b1;
                if (w_action == ACT_BATTERY) begin
                    r_bat_mild   <= n_bat_mild;
                    r_bat_severe <= n_bat_severe;
                    r_crit       <= n_crit;
                end else begin
                    r_motor_flags[w_motor_index] <= n_motor_byte;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // flag state only moves on an accepted beat, which frees the output slot, so the
    // stored flags are the pending result
    always_comb begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
            w_mild[5*m +: 5]   = r_motor_flags[m][4:0];
            w_severe[3*m +: 3] = r_motor_flags[m][7:5];
        end
        w_mild[22:20]   = r_bat_mild;
        w_severe[15:12] = r_bat_severe;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, (r_crit != 5'd0), (w_severe != 16'd0), (w_mild != 23'd0),
                            r_crit, w_severe, w_mild};

endmodule

// File: design/vffm_checker.sv
// vffm_checker: port-level checks for the fault-flag monitor, bound to the top level
`timescale 1ns / 1ps

module vffm_checker
    import vffm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a result beat waiting on the receiver stays put
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // every accepted input beat yields a result beat next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // the any-flags summarize their vectors
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[44] == (m_axis_tdata[22:0] != 23'd0))
                       && (m_axis_tdata[45] == (m_axis_tdata[38:23] != 16'd0))
                       && (m_axis_tdata[46] == (m_axis_tdata[43:39] != 5'd0)))
        else $error("any-flag does not match its flag vector");

    // the can link fault is sticky between result beats
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[39] ##1 m_axis_tvalid
        |-> m_axis_tdata[39])
        else $error("sticky can link fault cleared");

    // reset leaves no result pending
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind vehicle_fault_flag_monitor vffm_checker u_vffm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
